@@ src/ctf_pkg.sv @@
package ctf_pkg;

  // Commands carried by an input request.
  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_BYTE   = 2'd1,
    CMD_FLUSH  = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_t;

  // Result kinds.
  localparam logic KIND_BYTE     = 1'b0;
  localparam logic KIND_BOUNDARY = 1'b1;

  // Work handed from the front to the back.
  typedef enum logic [1:0] {
    JOB_START  = 2'd0,
    JOB_BYTE   = 2'd1,
    JOB_FLUSH  = 2'd2,
    JOB_FINISH = 2'd3
  } job_op_t;

  typedef struct packed {
    job_op_t     op;
    logic        pre_bnd;    // drain boundary ahead of the frame or terminator
    logic        last_byte;  // payload byte closes its chunk: CR LF follows
    logic        close_bnd;  // boundary after CR LF of a large frame
    logic [7:0]  data;
    logic [31:0] length;
    logic [3:0]  digits;     // hex digits of length, 1..8
  } job_t;

  // Back-end sequencer steps.
  typedef enum logic [2:0] {
    BK_NEW  = 3'd0,
    BK_PRE  = 3'd1,
    BK_HEX  = 3'd2,
    BK_DATA = 3'd3,
    BK_CR   = 3'd4,
    BK_LF   = 3'd5,
    BK_TERM = 3'd6,
    BK_POST = 3'd7
  } bk_state_t;

  localparam int          JOB_Q_DEPTH  = 4;
  localparam logic [12:0] LIMIT_MIN    = 13'd64;
  localparam logic [12:0] LIMIT_MAX    = 13'd4096;
  localparam logic [12:0] LARGE_MARGIN = 13'd32;
  localparam logic [12:0] LIMIT_RESET  = 13'd4096;
  localparam logic [47:0] TOTAL_MAX    = 48'hFFFF_FFFF_FFFF;
  localparam logic [2:0]  TERM_LAST    = 3'd4;

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;

  localparam logic [7:0] HEX_CHARS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  localparam logic [7:0] TERM_CHARS [5] = '{8'h30, 8'h0d, 8'h0a, 8'h0d, 8'h0a};

endpackage

@@ src/chunked_transfer_framer_unit.sv @@
// Chunked transfer framer. Each input request is classified on arrival by the
// front end, which keeps the open chunk length and the coalescing byte count,
// and is turned into a job in a four-entry queue; the back end sequencer
// expands each job into results at one result per clock, unless the output
// stalls, into an output register. A request causes one result for a payload
// byte in the middle of a chunk, three for the byte that closes a small chunk
// and four for one that closes a large chunk, digits + 2 (plus 1 with a drain
// boundary) for a chunk start, one for a flush and six or seven for finish.
// Requests that cause no result take no back-end time. Input accepts stall
// only while the job queue is full. The user writes the coalescing limit through
// the cfg port while the block idles; the block itself does not enforce this.
module chunked_transfer_framer_unit import ctf_pkg::*; #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_chunk_length,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_wire_byte,
  output logic [47:0] out_total_bytes,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_coalesce_limit
);

  logic [12:0] limit_r;
  logic        in_acc;
  logic        q_push;
  job_t        q_in;
  logic        q_pop;
  logic        q_full;
  logic        q_valid;
  job_t        q_head;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_coalesce_limit;
    end
  end

  ctf_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (in_acc),
    .command      (in_command),
    .chunk_length (in_chunk_length),
    .data_byte    (in_data_byte),
    .limit_raw    (limit_r),
    .enq          (q_push),
    .job          (q_in)
  );

  ctf_job_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_in),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_job   (q_head)
  );

  ctf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (q_valid),
    .job             (q_head),
    .job_pop         (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_wire_byte   (out_wire_byte),
    .out_total_bytes (out_total_bytes),
    .out_last        (out_last)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("job popped from an empty queue");

  a_boundary_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_BOUNDARY) |-> out_wire_byte == 8'd0)
    else $error("boundary result carries a byte");

  a_byte_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_BYTE) |-> out_total_bytes != 48'd0)
    else $error("wire byte delivered with a zero body total");

endmodule

@@ src/ctf_front.sv @@
module ctf_front import ctf_pkg::*; #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic [1:0]  command,
  input  logic [31:0] chunk_length,
  input  logic [7:0]  data_byte,
  input  logic [12:0] limit_raw,
  output logic        enq,
  output job_t        job
);

  localparam int          LEN_W    = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;
  localparam logic [31:0] LEN_MASK = 32'hFFFF_FFFF >> (32 - LEN_W);

  logic [12:0]      pending_r, pending_nxt;
  logic [LEN_W-1:0] left_r, left_nxt;
  logic             large_r, large_nxt;

  logic [31:0] len;
  logic [3:0]  digits;
  logic [12:0] limit;
  logic [12:0] thr;
  logic        is_small;
  logic [13:0] framed;
  logic [13:0] sum;
  logic        over;
  logic        open;

  always_comb begin
    len    = chunk_length & LEN_MASK;
    digits = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (len[i*4 +: 4] != 4'd0) digits = 4'(i + 1);
    end
    if (limit_raw < LIMIT_MIN) begin
      limit = LIMIT_MIN;
    end else if (limit_raw > LIMIT_MAX) begin
      limit = LIMIT_MAX;
    end else begin
      limit = limit_raw;
    end
    thr      = limit - LARGE_MARGIN;
    is_small = len < {19'd0, thr};
    // Only meaningful for a small frame, whose length fits in 13 bits.
    framed   = {10'd0, digits} + 14'd4 + {1'b0, len[12:0]};
    sum      = {1'b0, pending_r} + framed;
    over     = sum > {1'b0, limit};
    open     = left_r != '0;
  end

  always_comb begin
    pending_nxt   = pending_r;
    left_nxt      = left_r;
    large_nxt     = large_r;
    enq           = 1'b0;
    job.op        = JOB_BYTE;
    job.pre_bnd   = 1'b0;
    job.last_byte = 1'b0;
    job.close_bnd = 1'b0;
    job.data      = data_byte;
    job.length    = len;
    job.digits    = digits;
    if (acc) begin
      case (cmd_t'(command))
        CMD_BYTE: begin
          if (open) begin
            enq           = 1'b1;
            job.op        = JOB_BYTE;
            job.last_byte = left_r == LEN_W'(1);
            job.close_bnd = (left_r == LEN_W'(1)) && large_r;
            left_nxt      = left_r - LEN_W'(1);
            if (left_r == LEN_W'(1)) large_nxt = 1'b0;
          end
        end
        CMD_START: begin
          if (!open && len != 32'd0) begin
            enq      = 1'b1;
            job.op   = JOB_START;
            left_nxt = len[LEN_W-1:0];
            if (is_small) begin
              job.pre_bnd = over && (pending_r != 13'd0);
              pending_nxt = over ? framed[12:0] : sum[12:0];
              large_nxt   = 1'b0;
            end else begin
              job.pre_bnd = pending_r != 13'd0;
              pending_nxt = 13'd0;
              large_nxt   = 1'b1;
            end
          end
        end
        CMD_FLUSH: begin
          if (!open && pending_r != 13'd0) begin
            enq         = 1'b1;
            job.op      = JOB_FLUSH;
            pending_nxt = 13'd0;
          end
        end
        CMD_FINISH: begin
          if (!open) begin
            enq         = 1'b1;
            job.op      = JOB_FINISH;
            job.pre_bnd = ({1'b0, pending_r} + 14'd5) > {1'b0, limit};
            pending_nxt = 13'd0;
          end
        end
        default: begin
          enq = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 13'd0;
      left_r    <= '0;
      large_r   <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
      left_r    <= left_nxt;
      large_r   <= large_nxt;
    end
  end

endmodule

@@ src/ctf_job_queue.sv @@
module ctf_job_queue import ctf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head_job
);

  localparam int PTR_W = $clog2(JOB_Q_DEPTH);
  localparam int CNT_W = $clog2(JOB_Q_DEPTH + 1);

  job_t             entries_r [JOB_Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = count_r == CNT_W'(JOB_Q_DEPTH);
  assign head_valid = count_r != '0;
  assign head_job   = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ src/ctf_back.sv @@
module ctf_back import ctf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  input  job_t        job,
  output logic        job_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_wire_byte,
  output logic [47:0] out_total_bytes,
  output logic        out_last
);

  bk_state_t   state_r, state_nxt;
  bk_state_t   cur;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [47:0] emitted_r, emitted_nxt;

  logic        out_valid_r;
  logic        kind_r;
  logic [7:0]  byte_r;
  logic [47:0] total_r;
  logic        last_r;

  logic        step;
  logic        job_end;
  logic        hex_done;
  logic [2:0]  hex_idx;
  logic        res_kind;
  logic [7:0]  res_byte;
  logic [47:0] tot_inc;
  logic [47:0] res_total;

  assign step = job_valid && (!out_valid_r || !out_stall);

  always_comb begin
    if (state_r == BK_NEW) begin
      case (job.op)
        JOB_START:  cur = job.pre_bnd ? BK_PRE : BK_HEX;
        JOB_BYTE:   cur = BK_DATA;
        JOB_FLUSH:  cur = BK_POST;
        JOB_FINISH: cur = job.pre_bnd ? BK_PRE : BK_TERM;
        default:    cur = BK_POST;
      endcase
    end else begin
      cur = state_r;
    end
    // Hex digits go out most significant first; cnt_r counts digits sent.
    hex_idx  = 3'(job.digits - 4'd1 - {1'b0, cnt_r});
    hex_done = {1'b0, cnt_r} == (job.digits - 4'd1);
  end

  // Next step of the sequencer.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    job_end   = 1'b0;
    case (cur)
      BK_PRE: begin
        state_nxt = (job.op == JOB_START) ? BK_HEX : BK_TERM;
        cnt_nxt   = 3'd0;
      end
      BK_HEX: begin
        if (hex_done) begin
          state_nxt = BK_CR;
          cnt_nxt   = 3'd0;
        end else begin
          state_nxt = BK_HEX;
          cnt_nxt   = cnt_r + 3'd1;
        end
      end
      BK_DATA: begin
        state_nxt = BK_CR;
        job_end   = !job.last_byte;
      end
      BK_CR: begin
        state_nxt = BK_LF;
      end
      BK_LF: begin
        state_nxt = BK_POST;
        job_end   = !(job.op == JOB_BYTE && job.close_bnd);
      end
      BK_TERM: begin
        if (cnt_r == TERM_LAST) begin
          state_nxt = BK_POST;
          cnt_nxt   = 3'd0;
        end else begin
          state_nxt = BK_TERM;
          cnt_nxt   = cnt_r + 3'd1;
        end
      end
      BK_POST: begin
        job_end = 1'b1;
      end
      default: begin
        job_end = 1'b1;
      end
    endcase
    if (job_end) begin
      state_nxt = BK_NEW;
      cnt_nxt   = 3'd0;
    end
  end

  // Result produced by the current step.
  always_comb begin
    res_kind = KIND_BYTE;
    res_byte = 8'd0;
    case (cur)
      BK_PRE, BK_POST: res_kind = KIND_BOUNDARY;
      BK_HEX:          res_byte = HEX_CHARS[job.length[hex_idx*4 +: 4]];
      BK_DATA:         res_byte = job.data;
      BK_CR:           res_byte = CHAR_CR;
      BK_LF:           res_byte = CHAR_LF;
      BK_TERM:         res_byte = TERM_CHARS[cnt_r];
      default:         res_kind = KIND_BOUNDARY;
    endcase
    tot_inc   = (emitted_r == TOTAL_MAX) ? emitted_r : emitted_r + 48'd1;
    res_total = (res_kind == KIND_BYTE) ? tot_inc : emitted_r;
    // The body count starts over once the terminator has been framed.
    emitted_nxt = (job_end && job.op == JOB_FINISH) ? 48'd0 : res_total;
  end

  assign job_pop = step && job_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_NEW;
      cnt_r       <= 3'd0;
      emitted_r   <= 48'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        state_r     <= state_nxt;
        cnt_r       <= cnt_nxt;
        emitted_r   <= emitted_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      kind_r  <= res_kind;
      byte_r  <= res_byte;
      total_r <= res_total;
      last_r  <= job_end;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_wire_byte   = byte_r;
  assign out_total_bytes = total_r;
  assign out_last        = last_r;

endmodule

@@ test/chunked_transfer_framer_checker.sv @@
module chunked_transfer_framer_checker import ctf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_chunk_length,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_kind,
  input  logic [7:0]  out_wire_byte,
  input  logic [47:0] out_total_bytes,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [12:0] cfg_coalesce_limit,
  output int          fail_count,
  output int          waiting_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        kind;
    logic [7:0]  wire_byte;
    logic [47:0] total;
    logic        last;
  } wire_result_t;

  wire_result_t framed_q[$];

  logic [12:0] limit_copy = LIMIT_RESET;
  logic [12:0] pending_bytes = '0;
  logic [31:0] payload_remaining = '0;
  logic        large_open = 1'b0;
  logic [47:0] body_total = '0;

  initial begin
    fail_count = 0;
    waiting_results = 0;
  end

  function automatic int clamped_limit();
    int v;
    v = limit_copy;
    if (v < LIMIT_MIN) v = LIMIT_MIN;
    if (v > LIMIT_MAX) v = LIMIT_MAX;
    return v;
  endfunction

  task automatic push_result(input logic kind, input logic [7:0] b);
    wire_result_t r;
    if (kind == KIND_BYTE && body_total != TOTAL_MAX) body_total = body_total + 48'd1;
    r.kind = kind;
    r.wire_byte = (kind == KIND_BYTE) ? b : 8'h00;
    r.total = body_total;
    r.last = 1'b0;
    framed_q.push_back(r);
  endtask

  task automatic drain_pending();
    if (pending_bytes != 0) begin
      push_result(KIND_BOUNDARY, 8'h00);
      pending_bytes = '0;
    end
  endtask

  // Works out the wire bytes and write boundaries that one accepted request causes.
  task automatic frame_request(input cmd_t cmd, input logic [31:0] len,
                               input logic [7:0] data);
    int depth_before;
    int lim;
    int digits;
    int framed;
    int i;
    logic [31:0] t;
    wire_result_t r;
    depth_before = framed_q.size();
    lim = clamped_limit();
    if (cmd == CMD_BYTE) begin
      if (payload_remaining != 0) begin
        push_result(KIND_BYTE, data);
        payload_remaining = payload_remaining - 32'd1;
        if (payload_remaining == 0) begin
          push_result(KIND_BYTE, CHAR_CR);
          push_result(KIND_BYTE, CHAR_LF);
          if (large_open) begin
            push_result(KIND_BOUNDARY, 8'h00);
            large_open = 1'b0;
          end
        end
      end
    end else if (payload_remaining == 0) begin
      case (cmd)
        CMD_START: begin
          if (len != 0) begin
            digits = 0;
            t = len;
            while (t != 0) begin
              digits++;
              t = t >> 4;
            end
            if (len < 32'(lim - int'(LARGE_MARGIN))) begin
              framed = digits + 4 + int'(len);
              if (int'(pending_bytes) + framed > lim) drain_pending();
              pending_bytes = 13'(int'(pending_bytes) + framed);
              large_open = 1'b0;
            end else begin
              drain_pending();
              large_open = 1'b1;
            end
            for (i = digits; i > 0; i--) push_result(KIND_BYTE, HEX_CHARS[4'(len >> (4 * (i - 1)))]);
            push_result(KIND_BYTE, CHAR_CR);
            push_result(KIND_BYTE, CHAR_LF);
            payload_remaining = len;
          end
        end
        CMD_FLUSH: drain_pending();
        default: begin
          // The terminator goes out in the current send only if it still fits.
          if (int'(pending_bytes) + 5 > lim) drain_pending();
          for (i = 0; i < 5; i++) push_result(KIND_BYTE, TERM_CHARS[i]);
          push_result(KIND_BOUNDARY, 8'h00);
          pending_bytes = '0;
          body_total = '0;
        end
      endcase
    end
    if (framed_q.size() > depth_before) begin
      r = framed_q.pop_back();
      r.last = 1'b1;
      framed_q.push_back(r);
    end
  endtask

  task automatic compare_field(input string field, input logic [47:0] expd,
                               input logic [47:0] act);
    if (expd !== act) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, expd, act);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    wire_result_t expd;
    if (!rst_n) begin
      framed_q.delete();
      limit_copy = LIMIT_RESET;
      pending_bytes = '0;
      payload_remaining = '0;
      large_open = 1'b0;
      body_total = '0;
    end else begin
      if (cfg_valid && cfg_ready) limit_copy = cfg_coalesce_limit;
      if (in_valid && !in_stall) frame_request(cmd_t'(in_command), in_chunk_length, in_data_byte);
      if (out_valid && !out_stall) begin
        if (framed_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0h byte %0h total %0h",
                   $time, out_kind, out_wire_byte, out_total_bytes);
          fail_count++;
        end else begin
          expd = framed_q.pop_front();
          compare_field("kind", 48'(expd.kind), 48'(out_kind));
          compare_field("wire_byte", 48'(expd.wire_byte), 48'(out_wire_byte));
          compare_field("total_bytes", expd.total, out_total_bytes);
          compare_field("last", 48'(expd.last), 48'(out_last));
        end
      end
    end
    waiting_results <= framed_q.size();
  end

endmodule

@@ test/chunked_transfer_framer_unit_test.sv @@
module chunked_transfer_framer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ctf_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 30;
  localparam int PHASE_ITEMS   = 16;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = CMD_START;
  logic [31:0] in_chunk_length = '0;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [7:0]  out_wire_byte;
  logic [47:0] out_total_bytes;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [12:0] cfg_coalesce_limit = LIMIT_RESET;

  int fail_count;
  int waiting_results;
  int burst_left = 0;
  int framed_items = 0;

  chunked_transfer_framer_unit uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_chunk_length    (in_chunk_length),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_wire_byte      (out_wire_byte),
    .out_total_bytes    (out_total_bytes),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_coalesce_limit (cfg_coalesce_limit)
  );

  chunked_transfer_framer_checker framing_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_chunk_length    (in_chunk_length),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_wire_byte      (out_wire_byte),
    .out_total_bytes    (out_total_bytes),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_coalesce_limit (cfg_coalesce_limit),
    .fail_count         (fail_count),
    .waiting_results    (waiting_results)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // The receiver switches between stretches of no stall, light, heavy and run-length stall.
  int stall_mode = 0;
  int stall_phase_left = 0;
  int stall_run = 0;
  always @(posedge clk) begin
    if (stall_phase_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_phase_left <= $urandom_range(20, 150);
    end else begin
      stall_phase_left <= stall_phase_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_run == 0) begin
          out_stall <= !out_stall;
          stall_run <= $urandom_range(1, 16);
        end else begin
          stall_run <= stall_run - 1;
        end
      end
    endcase
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Returns at the edge where the request was taken; the caller drives the next
  // request or lowers valid in that same time step.
  task automatic send_request(input cmd_t cmd, input logic [31:0] len, input logic [7:0] data);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(30, 80);
      end else begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(0, 10);
      end
    end
    burst_left--;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_chunk_length <= len;
    in_data_byte <= data;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_chunk(input logic [31:0] len);
    int i;
    int pick;
    cmd_t noise_cmd;
    send_request(CMD_START, len, 8'($urandom));
    for (i = 0; i < len; i++) begin
      // Now and then a stray request lands inside the open chunk.
      if ($urandom_range(0, 19) == 0) begin
        pick = $urandom_range(0, 2);
        noise_cmd = (pick == 0) ? CMD_START : (pick == 1) ? CMD_FLUSH : CMD_FINISH;
        send_request(noise_cmd, $urandom(), 8'($urandom));
      end
      send_request(CMD_BYTE, $urandom(), 8'($urandom));
    end
    framed_items += int'(len) + 1;
  endtask

  task automatic write_limit(input logic [12:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_coalesce_limit <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [12:0] limits [5];
    int p;
    int pick;
    int phase_start;
    int lim;
    int thr;
    logic [31:0] len;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset limit.
    send_request(CMD_BYTE, 32'hFFFF_FFFF, 8'hFF);
    send_request(CMD_FLUSH, 32'h0, 8'h00);
    send_request(CMD_START, 32'h0, 8'h00);
    send_request(CMD_FINISH, 32'h0, 8'h00);
    send_request(CMD_START, 32'h1, 8'h00);
    send_request(CMD_BYTE, 32'h0, 8'h00);
    send_request(CMD_START, 32'h2, 8'h00);
    send_request(CMD_FLUSH, 32'h0, 8'h00);
    send_request(CMD_START, 32'h5, 8'h00);
    send_request(CMD_FINISH, 32'h0, 8'h00);
    send_request(CMD_BYTE, 32'h0, 8'hFF);
    send_request(CMD_BYTE, 32'hFFFF_FFFF, 8'h80);
    send_request(CMD_FLUSH, 32'h0, 8'h00);
    send_request(CMD_FLUSH, 32'h0, 8'h00);
    send_request(CMD_START, 32'hC, 8'h00);
    repeat (12) send_request(CMD_BYTE, 32'h0, 8'($urandom));
    send_request(CMD_FINISH, 32'hFFFF_FFFF, 8'hFF);

    limits[0] = 13'd64;
    limits[1] = 13'd8191;
    limits[2] = 13'd96;
    limits[3] = 13'd0;
    limits[4] = 13'($urandom_range(64, 160));

    for (p = 0; p < 5; p++) begin
      write_limit(limits[p]);
      lim = limits[p];
      if (lim < 64) lim = 64;
      if (lim > 4096) lim = 4096;
      thr = lim - 32;
      phase_start = framed_items;
      while (framed_items - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          pick = $urandom_range(0, 99);
          if (pick < 70) len = $urandom_range(1, 6);
          else if (pick < 88) len = $urandom_range(7, 20);
          else if (thr <= 40) len = $urandom_range(thr - 1, thr + 1);
          else len = $urandom_range(21, 40);
          send_chunk(len);
        end else if (pick < 72) begin
          send_request(CMD_FLUSH, $urandom(), 8'($urandom));
          framed_items++;
        end else if (pick < 82) begin
          send_request(CMD_FINISH, $urandom(), 8'($urandom));
          framed_items++;
        end else if (pick < 91) begin
          send_request(CMD_BYTE, $urandom(), 8'($urandom));
        end else begin
          send_request(CMD_START, 32'h0, 8'($urandom));
        end
      end
    end

    // The longest length opens a chunk that is never closed, so it comes last.
    send_request(CMD_START, 32'hFFFF_FFFF, 8'h00);
    repeat (3) send_request(CMD_BYTE, $urandom(), 8'($urandom));
    in_valid <= 1'b0;

    @(posedge clk);
    while (waiting_results != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/ctf_pkg.sv
src/ctf_front.sv
src/ctf_job_queue.sv
src/ctf_back.sv
src/chunked_transfer_framer_unit.sv
test/chunked_transfer_framer_checker.sv
test/chunked_transfer_framer_unit_test.sv
